>>> src/nrfp_pkg.sv
// Shared types and constants of the NFC response frame parser.
package nrfp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_IDX_W = 1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_COMMAND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD      = 1'd1;

   localparam logic [BYTE_W-1:0] EXPECTED_COMMAND_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET      = 8'd19;

   // Frame bytes
   localparam logic [BYTE_W-1:0] START_BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] START_BYTE_FF   = 8'hFF;
   localparam logic [BYTE_W-1:0] FRAME_ID        = 8'hD5;
   localparam logic [BYTE_W-1:0] POSTAMBLE_BYTE  = 8'h00;
   localparam logic [BYTE_W-1:0] LEN_OVERHEAD    = 8'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_START = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LCS   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SIZE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CMD   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DCS   = 3'd5;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic                is_status;
      logic [BYTE_W-1:0]   payload_byte;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_count;
   } rsp_type;

   // Handshake between the request stage and the parser
   typedef struct packed {
      logic step;
      logic has_result;
   } step_ctl_type;

endpackage

>>> src/nrfp_if.sv
// Request and response channel interfaces of the NFC response frame parser.
interface nrfp_req_if
   import nrfp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              restart;

   modport source (output valid, output rx_byte, output restart, input ready);
   modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface nrfp_rsp_if
   import nrfp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                is_status;
   logic [BYTE_W-1:0]   payload_byte;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   payload_count;

   modport source (output valid, output is_status, output payload_byte,
                   output status, output payload_count, input ready);
   modport sink   (input valid, input is_status, input payload_byte,
                   input status, input payload_count, output ready);
endinterface

>>> src/nfc_response_frame_parser.sv
// A request's result (payload byte or status) is held in the input register and then registered in the result register.
// Throughput: one request per cycle; the input register, the single-step frame decode and
// the result register each take one byte per cycle, so only rsp ready backpressure slows it.
// Requests that produce no result (well-formed start bytes, LEN, LCS, identifier, code, DCS) retire
// without using the result register.
// Reset (synchronous, active high): parser back to start-byte hunt, both stages empty,
// expected_command to 0 and max_payload to 19.
module nfc_response_frame_parser
   import nrfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   nrfp_req_if.sink             req_ch,
   nrfp_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   // Configuration registers
   logic [BYTE_W-1:0] expected_command_ff;
   logic [BYTE_W-1:0] max_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_command_ff <= EXPECTED_COMMAND_RESET;
         max_payload_ff      <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPECTED_COMMAND: expected_command_ff <= csr_wdata;
            CSR_MAX_PAYLOAD:      max_payload_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   req_type      req_data;
   req_type      held_req;
   step_ctl_type ctl;
   logic         has_result;
   rsp_type      result;
   logic         out_can_accept;
   rsp_type      rsp_data;

   assign req_data.rx_byte = req_ch.rx_byte;
   assign req_data.restart = req_ch.restart;

   // Hold the request here until the parser can retire it
   nrfp_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_ch.valid),
      .in_ready       (req_ch.ready),
      .in_data        (req_data),
      .out_can_accept (out_can_accept),
      .has_result     (has_result),
      .ctl            (ctl),
      .held_data      (held_req)
   );

   // Decode the held byte against the frame position; advance state on retire
   nrfp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (ctl.step),
      .req              (held_req),
      .expected_command (expected_command_ff),
      .max_payload      (max_payload_ff),
      .has_result       (has_result),
      .result           (result)
   );

   // Register the result; a waiting result does not block requests without one
   nrfp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (ctl.has_result),
      .load_data  (result),
      .can_accept (out_can_accept),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_data   (rsp_data)
   );

   assign rsp_ch.is_status     = rsp_data.is_status;
   assign rsp_ch.payload_byte  = rsp_data.payload_byte;
   assign rsp_ch.status        = rsp_data.status;
   assign rsp_ch.payload_count = rsp_data.payload_count;

`ifndef ASSERT_OFF
   // A restart request never yields a result
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      ctl.step && held_req.restart |-> !ctl.has_result)
      else $error("restart request produced a result");

   // A result is only loaded when the result register has room
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.has_result |-> out_can_accept)
      else $error("result register overwritten");

   // An ok status never reports more payload than the configured limit
   a_ok_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_status && rsp_ch.status == ST_OK
         |-> rsp_ch.payload_count <= max_payload_ff)
      else $error("ok status with payload count above limit");

   // Error statuses and payload results carry a zero count
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !(rsp_ch.is_status && rsp_ch.status == ST_OK)
         |-> rsp_ch.payload_count == 8'd0)
      else $error("nonzero payload count outside ok status");
`endif

endmodule

>>> src/nrfp_in_stage.sv
// Input register of the NFC response frame parser.
module nrfp_in_stage
   import nrfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   input  logic    out_can_accept,
   input  logic    has_result,
   output step_ctl_type ctl,
   output req_type held_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    advance;

   // Advance when the result slot is free or no result comes from this byte
   assign advance   = valid_ff & (~has_result | out_can_accept);
   assign in_ready  = ~valid_ff | advance;
   assign valid_in  = (in_valid & in_ready) | (valid_ff & ~advance);

   assign ctl.step       = advance;
   assign ctl.has_result = advance & has_result;
   assign held_data      = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

>>> src/nrfp_parser.sv
// Frame walk state and per-byte decode of the NFC response frame parser.
module nrfp_parser
   import nrfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  req_type           req,
   input  logic [BYTE_W-1:0] expected_command,
   input  logic [BYTE_W-1:0] max_payload,
   output logic              has_result,
   output rsp_type           result
);

   localparam logic [3:0] PH_START0 = 4'd0;
   localparam logic [3:0] PH_START1 = 4'd1;
   localparam logic [3:0] PH_START2 = 4'd2;
   localparam logic [3:0] PH_LEN    = 4'd3;
   localparam logic [3:0] PH_LCS    = 4'd4;
   localparam logic [3:0] PH_TFI    = 4'd5;
   localparam logic [3:0] PH_CODE   = 4'd6;
   localparam logic [3:0] PH_DATA   = 4'd7;
   localparam logic [3:0] PH_DCS    = 4'd8;
   localparam logic [3:0] PH_POST   = 4'd9;

   logic [3:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] frame_length_ff, frame_length_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] running_sum_ff, running_sum_in;

   logic [BYTE_W-1:0]   b;
   logic [BYTE_W-1:0]   code;
   logic [BYTE_W-1:0]   len_sum;
   logic [BYTE_W-1:0]   data_sum;
   logic [BYTE_W-1:0]   dcs_sum;
   logic [BYTE_W-1:0]   payload_len;
   logic [BYTE_W-1:0]   left_dec;
   logic                err;
   logic [STATUS_W-1:0] err_code;
   logic                clear;

   assign b           = req.rx_byte;
   assign code        = expected_command + 8'd1;
   assign len_sum     = frame_length_ff + b;
   assign data_sum    = running_sum_ff + b;
   assign dcs_sum     = running_sum_ff + b;
   assign payload_len = frame_length_ff - LEN_OVERHEAD;
   assign left_dec    = bytes_left_ff - 8'd1;

   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      has_result      = 1'b0;
      result          = '0;
      err             = 1'b0;
      err_code        = ST_OK;
      clear           = 1'b0;

      if (req.restart) begin
         clear = 1'b1;
      end else begin
         case (phase_ff)
            PH_START1: begin
               if (b != START_BYTE_ZERO) begin
                  err = 1'b1;  err_code = ST_START;
               end else begin
                  phase_in = PH_START2;
               end
            end
            PH_START2: begin
               if (b != START_BYTE_FF) begin
                  err = 1'b1;  err_code = ST_START;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               frame_length_in = b;
               phase_in        = PH_LCS;
            end
            PH_LCS: begin
               if (len_sum != 8'd0) begin
                  err = 1'b1;  err_code = ST_LCS;
               end else if (frame_length_ff < LEN_OVERHEAD || payload_len > max_payload) begin
                  err = 1'b1;  err_code = ST_SIZE;
               end else begin
                  running_sum_in = 8'd0;
                  phase_in       = PH_TFI;
               end
            end
            PH_TFI: begin
               if (b != FRAME_ID) begin
                  err = 1'b1;  err_code = ST_CMD;
               end else begin
                  running_sum_in = data_sum;
                  phase_in       = PH_CODE;
               end
            end
            PH_CODE: begin
               if (b != code) begin
                  err = 1'b1;  err_code = ST_CMD;
               end else begin
                  running_sum_in = data_sum;
                  bytes_left_in  = payload_len;
                  phase_in       = (payload_len == 8'd0) ? PH_DCS : PH_DATA;
               end
            end
            PH_DATA: begin
               running_sum_in      = data_sum;
               bytes_left_in       = left_dec;
               if (left_dec == 8'd0) begin
                  phase_in = PH_DCS;
               end
               has_result          = 1'b1;
               result.payload_byte = b;
            end
            PH_DCS: begin
               if (dcs_sum != 8'd0) begin
                  err = 1'b1;  err_code = ST_DCS;
               end else begin
                  phase_in = PH_POST;
               end
            end
            PH_POST: begin
               if (b != POSTAMBLE_BYTE) begin
                  err = 1'b1;  err_code = ST_DCS;
               end else begin
                  has_result           = 1'b1;
                  result.is_status     = 1'b1;
                  result.status        = ST_OK;
                  result.payload_count = payload_len;
                  clear                = 1'b1;
               end
            end
            default: begin
               // First start byte; unused phase codes hunt here too
               if (b != START_BYTE_ZERO) begin
                  err = 1'b1;  err_code = ST_START;
               end else begin
                  phase_in = PH_START1;
               end
            end
         endcase
      end

      if (err) begin
         has_result    = 1'b1;
         result.is_status = 1'b1;
         result.status = err_code;
         clear         = 1'b1;
      end

      if (clear) begin
         phase_in        = PH_START0;
         frame_length_in = 8'd0;
         bytes_left_in   = 8'd0;
         running_sum_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START0;
         frame_length_ff <= 8'd0;
         bytes_left_ff   <= 8'd0;
         running_sum_ff  <= 8'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
      end
   end

endmodule

>>> src/nrfp_out_stage.sv
// Result register of the NFC response frame parser.
module nrfp_out_stage
   import nrfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    can_accept,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_accept = ~valid_ff | out_ready;
   assign valid_in   = load | (valid_ff & ~out_ready);
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule
